// ===== hdl/irm_pkg.sv =====
// Interface rate meter: shared widths, constants, state encodings and record types.
// No dependencies; irm_div and the top level in hdl/ refer to it by scoped names.
package irm_pkg;

    localparam int IDX_IN_W   = 4;     // interface index as carried on the input
    localparam int CNT_W      = 64;    // byte counters and whole parts
    localparam int TIME_W     = 32;    // elapsed milliseconds
    localparam int FRAC_W     = 10;    // thousandths
    localparam int CTR_W      = 6;     // bit counter of the serial divider
    localparam int KILO_W     = CNT_W + 2;
    localparam int KILO_SHIFT = 7;     // 1000/1024 == 125/128
    localparam int KILO_ROUND = 127;   // turns floor into ceil for 3d/128
    localparam int UNIT_SHIFT = 3;     // bytes to bits
    localparam int MS_SCALE   = 1000;
    localparam int FRAC_LIMIT = 1000;
    localparam int FRAC_MAX   = 999;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_FIRST     = 2'd1,
        ST_ZERO_TIME = 2'd2
    } status_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DELTA = 7'b0000010,
        S_KILO1 = 7'b0000100,
        S_KILO2 = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_SUM   = 7'b0100000,
        S_WRITE = 7'b1000000
    } seq_state_t;

    typedef enum logic [3:0] {
        D_IDLE  = 4'b0001,
        D_WHOLE = 4'b0010,
        D_SCALE = 4'b0100,
        D_FRAC  = 4'b1000
    } div_state_t;

    // one per-interface record in the state memory
    typedef struct packed {
        logic [CNT_W-1:0]  prev_rx;
        logic [CNT_W-1:0]  prev_tx;
        logic [CNT_W-1:0]  peak_rx_whole;
        logic [FRAC_W-1:0] peak_rx_frac;
        logic [CNT_W-1:0]  peak_tx_whole;
        logic [FRAC_W-1:0] peak_tx_frac;
    } entry_t;

    // divider result towards the sequencer
    typedef struct packed {
        logic              done;
        logic [CNT_W-1:0]  whole;
        logic [FRAC_W-1:0] frac;
    } div_res_t;

endpackage

// ===== hdl/irm_ram.sv =====
// Interface rate meter: generic single-port-write, single-port-read RAM.
// Registered read data; no dependencies.
module irm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/irm_div.sv =====
// Interface rate meter: bit-serial restoring divider giving whole part and thousandths.
// Depends on irm_pkg.
module irm_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [irm_pkg::CNT_W-1:0]   dividend,
    input  logic [irm_pkg::TIME_W-1:0]  divisor,
    output irm_pkg::div_res_t           res
);

    irm_pkg::div_state_t state_reg, state_next;

    logic [irm_pkg::CTR_W-1:0]    ctr_reg, ctr_next;
    logic                         done_reg, done_next;
    logic [irm_pkg::CNT_W-1:0]    q_reg;
    logic [irm_pkg::FRAC_W-1:0]   f_reg;
    logic [irm_pkg::TIME_W-1:0]   r_reg;
    logic [irm_pkg::TIME_W-1:0]   t_reg;

    logic                         bit_in;
    logic [irm_pkg::TIME_W:0]     r_shift;
    logic [irm_pkg::TIME_W:0]     r_diff;
    logic                         fits;
    logic [irm_pkg::TIME_W-1:0]   r_step;
    logic [irm_pkg::TIME_W+irm_pkg::FRAC_W-1:0] r_scaled;

    // one quotient bit per cycle
    assign bit_in  = (state_reg == irm_pkg::D_FRAC) ? f_reg[irm_pkg::FRAC_W-1]
                                                    : q_reg[irm_pkg::CNT_W-1];
    assign r_shift = {r_reg, bit_in};
    assign r_diff  = r_shift - {1'b0, t_reg};
    assign fits    = (r_shift >= {1'b0, t_reg});
    assign r_step  = fits ? r_diff[irm_pkg::TIME_W-1:0] : r_shift[irm_pkg::TIME_W-1:0];

    // remainder * 1000; high part is below the divisor, low 10 bits feed the frac pass
    assign r_scaled = {{irm_pkg::FRAC_W{1'b0}}, r_reg}
                    * (irm_pkg::TIME_W + irm_pkg::FRAC_W)'(irm_pkg::MS_SCALE);

    always_comb begin
        state_next = state_reg;
        ctr_next   = ctr_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            irm_pkg::D_IDLE: begin
                if (start) begin
                    state_next = irm_pkg::D_WHOLE;
                    ctr_next   = '0;
                end
            end
            irm_pkg::D_WHOLE: begin
                ctr_next = ctr_reg + 1'b1;
                if (ctr_reg == irm_pkg::CTR_W'(irm_pkg::CNT_W - 1)) begin
                    state_next = irm_pkg::D_SCALE;
                end
            end
            irm_pkg::D_SCALE: begin
                state_next = irm_pkg::D_FRAC;
                ctr_next   = '0;
            end
            irm_pkg::D_FRAC: begin
                ctr_next = ctr_reg + 1'b1;
                if (ctr_reg == irm_pkg::CTR_W'(irm_pkg::FRAC_W - 1)) begin
                    state_next = irm_pkg::D_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: begin
                state_next = irm_pkg::D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= irm_pkg::D_IDLE;
            ctr_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            irm_pkg::D_IDLE: begin
                if (start) begin
                    q_reg <= dividend;
                    t_reg <= divisor;
                    r_reg <= '0;
                end
            end
            irm_pkg::D_WHOLE: begin
                q_reg <= {q_reg[irm_pkg::CNT_W-2:0], fits};
                r_reg <= r_step;
            end
            irm_pkg::D_SCALE: begin
                r_reg <= r_scaled[irm_pkg::TIME_W+irm_pkg::FRAC_W-1:irm_pkg::FRAC_W];
                f_reg <= r_scaled[irm_pkg::FRAC_W-1:0];
            end
            irm_pkg::D_FRAC: begin
                f_reg <= {f_reg[irm_pkg::FRAC_W-2:0], fits};
                r_reg <= r_step;
            end
            default: begin
                r_reg <= r_reg;
            end
        endcase
    end

    assign res.done  = done_reg;
    assign res.whole = q_reg;
    assign res.frac  = f_reg;

endmodule

// ===== hdl/interface_rate_meter_unit.sv =====
// Interface rate meter, top level: handshakes, per-interface state memory,
// sequencer and result register. Depends on irm_pkg, irm_ram and irm_div.
//
// Input words (s_t*) carry one counter sample: interface index on s_tuser,
// cumulative rx/tx byte counters and elapsed milliseconds on s_tdata. Each
// accepted word yields one result word (m_t*): rx, tx and summed rates as whole
// part plus thousandths, the interface's held peaks, and a status on m_tuser.
// cfg_wen/cfg_wdata set the counting unit (0 bits, 1 bytes); write it while idle.
//
// One word at a time; s_tready is high only while the sequencer is idle. A rate
// sample passes memory read and delta, 125/128 scaling in KILO1 and KILO2, then
// 64 quotient bits, a scaling step and 10 thousandths bits in two bit-serial
// dividers run side by side, then sum/peak and write-back, after which the
// sequencer returns to idle for the next word. A first sample or a zero elapsed
// time skips the scaling and the dividers.
//
// Reset clears the seen flags, so an interface reads as all-zero state until
// its first sample is written; no clearing pass. A new word is taken while the
// previous result waits; a finished result is held in write-back until the
// result register is free, and m_tdata/m_tuser hold while stalled.
module interface_rate_meter_unit #(
    parameter int NUM_IFACES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wen,
    input  logic         cfg_wdata,   // count_unit
    // sample input
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,     // rx_counter[63:0], tx_counter[127:64],
                                      // elapsed_ms[159:128]
    input  logic [3:0]   s_tuser,     // iface_index
    // result output
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [375:0] m_tdata,     // rx_whole[63:0], rx_frac[73:64],
                                      // tx_whole[137:74], tx_frac[147:138],
                                      // sum_whole[211:148], sum_frac[221:212],
                                      // rx_peak_whole[285:222], rx_peak_frac[295:286],
                                      // tx_peak_whole[359:296], tx_peak_frac[369:360],
                                      // zero pad [375:370]
    output logic [1:0]   m_tuser      // status
);

    localparam int IDX_W   = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
    localparam int IDX_NUM = 1 << irm_pkg::IDX_IN_W;
    localparam int CW      = irm_pkg::CNT_W;
    localparam int FW      = irm_pkg::FRAC_W;
    localparam int KW      = irm_pkg::KILO_W;
    localparam int PAD_W   = 376 - (5 * (CW + FW));

    // ---------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------
    irm_pkg::seq_state_t state_reg, state_next;

    logic                  count_unit_reg;
    logic [NUM_IFACES-1:0] seen_reg;
    logic                  m_tvalid_reg;

    // ---------------------------------------------------------------
    // item payload
    // ---------------------------------------------------------------
    logic [IDX_W-1:0]          idx_reg;
    logic                      seen_hit_reg;
    logic [CW-1:0]             rx_new_reg, tx_new_reg;
    logic [irm_pkg::TIME_W-1:0] time_reg;
    logic [CW-1:0]             rx_d_reg, tx_d_reg;
    logic [KW-1:0]             rx_t3_reg, tx_t3_reg;
    logic [CW-1:0]             pk_rx_w_reg, pk_tx_w_reg;
    logic [FW-1:0]             pk_rx_f_reg, pk_tx_f_reg;
    logic [CW-1:0]             sum_w_reg;
    logic [FW-1:0]             sum_f_reg;
    irm_pkg::status_t          status_reg;
    logic [375:0]              m_tdata_reg;
    logic [1:0]                m_tuser_reg;

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------
    logic             in_acc;
    logic [IDX_W-1:0] mod_tab [IDX_NUM];
    logic [IDX_W-1:0] in_idx;
    logic [CW-1:0]    rx_in, tx_in, rx_scaled, tx_scaled;

    // index modulo the interface count, folded at elaboration
    for (genvar g = 0; g < IDX_NUM; g++) begin : g_mod
        assign mod_tab[g] = IDX_W'(g % NUM_IFACES);
    end

    assign s_tready  = (state_reg == irm_pkg::S_IDLE);
    assign in_acc    = s_tvalid & s_tready;
    assign in_idx    = mod_tab[s_tuser];
    assign rx_in     = s_tdata[63:0];
    assign tx_in     = s_tdata[127:64];
    assign rx_scaled = count_unit_reg ? rx_in : {rx_in[CW-1-irm_pkg::UNIT_SHIFT:0],
                                                 {irm_pkg::UNIT_SHIFT{1'b0}}};
    assign tx_scaled = count_unit_reg ? tx_in : {tx_in[CW-1-irm_pkg::UNIT_SHIFT:0],
                                                 {irm_pkg::UNIT_SHIFT{1'b0}}};

    // ---------------------------------------------------------------
    // per-interface state memory
    // ---------------------------------------------------------------
    irm_pkg::entry_t rd_entry, wr_entry;
    logic            wr_commit;
    logic            out_free;

    irm_ram #(
        .WIDTH ($bits(irm_pkg::entry_t)),
        .DEPTH (NUM_IFACES)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (wr_commit),
        .wr_addr (idx_reg),
        .wr_data (wr_entry),
        .rd_en   (in_acc),
        .rd_addr (in_idx),
        .rd_data (rd_entry)
    );

    assign wr_entry.prev_rx       = rx_new_reg;
    assign wr_entry.prev_tx       = tx_new_reg;
    assign wr_entry.peak_rx_whole = pk_rx_w_reg;
    assign wr_entry.peak_rx_frac  = pk_rx_f_reg;
    assign wr_entry.peak_tx_whole = pk_tx_w_reg;
    assign wr_entry.peak_tx_frac  = pk_tx_f_reg;

    // ---------------------------------------------------------------
    // 125/128 scaling: kd = d - ceil(3d/128)
    // ---------------------------------------------------------------
    logic [KW-1:0] rx_t3, tx_t3;
    logic [CW-1:0] rx_kd, tx_kd;

    assign rx_t3 = {2'b00, rx_d_reg} + {1'b0, rx_d_reg, 1'b0} + KW'(irm_pkg::KILO_ROUND);
    assign tx_t3 = {2'b00, tx_d_reg} + {1'b0, tx_d_reg, 1'b0} + KW'(irm_pkg::KILO_ROUND);
    assign rx_kd = rx_d_reg - CW'(rx_t3_reg[KW-1:irm_pkg::KILO_SHIFT]);
    assign tx_kd = tx_d_reg - CW'(tx_t3_reg[KW-1:irm_pkg::KILO_SHIFT]);

    // ---------------------------------------------------------------
    // dividers, one per direction
    // ---------------------------------------------------------------
    irm_pkg::div_res_t rx_res, tx_res;
    logic              div_start;

    assign div_start = (state_reg == irm_pkg::S_KILO2);

    irm_div u_rx_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rx_kd),
        .divisor  (time_reg),
        .res      (rx_res)
    );

    irm_div u_tx_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (tx_kd),
        .divisor  (time_reg),
        .res      (tx_res)
    );

    // ---------------------------------------------------------------
    // sum with carry at 1000 thousandths, saturating; peak compare
    // ---------------------------------------------------------------
    logic [FW:0]  frac_sum, frac_adj;
    logic         frac_carry;
    logic [CW:0]  whole_sum;
    logic         rx_beats, tx_beats;

    assign frac_sum   = {1'b0, rx_res.frac} + {1'b0, tx_res.frac};
    assign frac_carry = (frac_sum >= (FW + 1)'(irm_pkg::FRAC_LIMIT));
    assign frac_adj   = frac_carry ? frac_sum - (FW + 1)'(irm_pkg::FRAC_LIMIT) : frac_sum;
    assign whole_sum  = {1'b0, rx_res.whole} + {1'b0, tx_res.whole} + (CW + 1)'(frac_carry);

    // whole first, then thousandths; frac < 1000 so concatenation orders correctly
    assign rx_beats = ({rx_res.whole, rx_res.frac} > {pk_rx_w_reg, pk_rx_f_reg});
    assign tx_beats = ({tx_res.whole, tx_res.frac} > {pk_tx_w_reg, pk_tx_f_reg});

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    assign out_free  = !m_tvalid_reg || m_tready;
    assign wr_commit = (state_reg == irm_pkg::S_WRITE) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            irm_pkg::S_IDLE: begin
                if (in_acc) begin
                    state_next = irm_pkg::S_DELTA;
                end
            end
            irm_pkg::S_DELTA: begin
                if (!seen_hit_reg || (time_reg == '0)) begin
                    state_next = irm_pkg::S_WRITE;
                end else begin
                    state_next = irm_pkg::S_KILO1;
                end
            end
            irm_pkg::S_KILO1: begin
                state_next = irm_pkg::S_KILO2;
            end
            irm_pkg::S_KILO2: begin
                state_next = irm_pkg::S_DIV;
            end
            irm_pkg::S_DIV: begin
                if (rx_res.done) begin
                    state_next = irm_pkg::S_SUM;
                end
            end
            irm_pkg::S_SUM: begin
                state_next = irm_pkg::S_WRITE;
            end
            irm_pkg::S_WRITE: begin
                if (out_free) begin
                    state_next = irm_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = irm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= irm_pkg::S_IDLE;
            count_unit_reg <= 1'b0;
            seen_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wen) begin
                count_unit_reg <= cfg_wdata;
            end
            if (wr_commit) begin
                seen_reg[idx_reg] <= 1'b1;
            end
            if (wr_commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    logic status_ok;

    assign status_ok = (status_reg == irm_pkg::ST_VALID);

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            idx_reg      <= in_idx;
            seen_hit_reg <= seen_reg[in_idx];
            rx_new_reg   <= rx_scaled;
            tx_new_reg   <= tx_scaled;
            time_reg     <= s_tdata[159:128];
        end

        case (state_reg)
            irm_pkg::S_DELTA: begin
                rx_d_reg <= rx_new_reg - rd_entry.prev_rx;
                tx_d_reg <= tx_new_reg - rd_entry.prev_tx;
                // an interface never written reads as all zero
                if (seen_hit_reg) begin
                    pk_rx_w_reg <= rd_entry.peak_rx_whole;
                    pk_rx_f_reg <= rd_entry.peak_rx_frac;
                    pk_tx_w_reg <= rd_entry.peak_tx_whole;
                    pk_tx_f_reg <= rd_entry.peak_tx_frac;
                end else begin
                    pk_rx_w_reg <= '0;
                    pk_rx_f_reg <= '0;
                    pk_tx_w_reg <= '0;
                    pk_tx_f_reg <= '0;
                end
                if (!seen_hit_reg) begin
                    status_reg <= irm_pkg::ST_FIRST;
                end else if (time_reg == '0) begin
                    status_reg <= irm_pkg::ST_ZERO_TIME;
                end else begin
                    status_reg <= irm_pkg::ST_VALID;
                end
            end
            irm_pkg::S_KILO1: begin
                rx_t3_reg <= rx_t3;
                tx_t3_reg <= tx_t3;
            end
            irm_pkg::S_SUM: begin
                if (whole_sum[CW]) begin
                    sum_w_reg <= '1;
                    sum_f_reg <= FW'(irm_pkg::FRAC_MAX);
                end else begin
                    sum_w_reg <= whole_sum[CW-1:0];
                    sum_f_reg <= frac_adj[FW-1:0];
                end
                if (rx_beats) begin
                    pk_rx_w_reg <= rx_res.whole;
                    pk_rx_f_reg <= rx_res.frac;
                end
                if (tx_beats) begin
                    pk_tx_w_reg <= tx_res.whole;
                    pk_tx_f_reg <= tx_res.frac;
                end
            end
            default: begin
            end
        endcase

        if (wr_commit) begin
            m_tdata_reg <= {{PAD_W{1'b0}},
                            pk_tx_f_reg, pk_tx_w_reg,
                            pk_rx_f_reg, pk_rx_w_reg,
                            status_ok ? sum_f_reg    : {FW{1'b0}},
                            status_ok ? sum_w_reg    : {CW{1'b0}},
                            status_ok ? tx_res.frac  : {FW{1'b0}},
                            status_ok ? tx_res.whole : {CW{1'b0}},
                            status_ok ? rx_res.frac  : {FW{1'b0}},
                            status_ok ? rx_res.whole : {CW{1'b0}}};
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for interface_rate_meter_unit: counter samples in, rate words out.
// Depends on irm_pkg and the unit under hdl/; predicts each result word from its own rate model.
`timescale 1ns / 1ps

module tb;

    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the unit
    localparam int PHASE_ITEMS  = 270;
    localparam int SETTLE       = 100;   // longer than a rate sample's latency

    // one counter sample as carried on the input side
    typedef struct {
        logic [irm_pkg::IDX_IN_W-1:0] iface;
        logic [irm_pkg::CNT_W-1:0]    rx;
        logic [irm_pkg::CNT_W-1:0]    tx;
        logic [irm_pkg::TIME_W-1:0]   ms;
    } sample_t;

    // one result word, fields from the top of m_tdata down, then the status
    typedef struct packed {
        logic [irm_pkg::FRAC_W-1:0] tx_peak_frac;
        logic [irm_pkg::CNT_W-1:0]  tx_peak_whole;
        logic [irm_pkg::FRAC_W-1:0] rx_peak_frac;
        logic [irm_pkg::CNT_W-1:0]  rx_peak_whole;
        logic [irm_pkg::FRAC_W-1:0] sum_frac;
        logic [irm_pkg::CNT_W-1:0]  sum_whole;
        logic [irm_pkg::FRAC_W-1:0] tx_frac;
        logic [irm_pkg::CNT_W-1:0]  tx_whole;
        logic [irm_pkg::FRAC_W-1:0] rx_frac;
        logic [irm_pkg::CNT_W-1:0]  rx_whole;
        irm_pkg::status_t           status;
    } rate_result_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_wen   = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata   = '0;    // rx_counter, tx_counter, elapsed_ms
    logic [3:0]   s_tuser   = '0;    // iface_index
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [375:0] m_tdata;           // rx/tx/sum rates, rx/tx peaks, zero pad
    logic [1:0]   m_tuser;           // status

    interface_rate_meter_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // queues and counters
    sample_t      pending_samples[$];
    rate_result_t expected_rates[$];
    int unsigned  samples_queued = 0;
    int unsigned  samples_taken  = 0;
    int unsigned  mismatch_count = 0;
    logic         took_word      = 1'b0;
    logic         quiet          = 1'b0;   // no idling on either side
    logic         hold_req       = 1'b0;   // toggled to ask for a hold-off
    logic         hold_ack       = 1'b0;
    int unsigned  stall_left     = 0;

    // predictor state, per interface
    logic                       unit_bytes = 1'b0;
    logic [irm_pkg::CNT_W-1:0]  prev_rx   [16] = '{default: '0};
    logic [irm_pkg::CNT_W-1:0]  prev_tx   [16] = '{default: '0};
    logic [irm_pkg::CNT_W-1:0]  peak_rx_w [16] = '{default: '0};
    logic [irm_pkg::FRAC_W-1:0] peak_rx_f [16] = '{default: '0};
    logic [irm_pkg::CNT_W-1:0]  peak_tx_w [16] = '{default: '0};
    logic [irm_pkg::FRAC_W-1:0] peak_tx_f [16] = '{default: '0};
    logic                       seen      [16] = '{default: 1'b0};

    // stimulus-side copy of the last raw counters, for well-formed increments
    logic [irm_pkg::CNT_W-1:0]  gen_rx [16] = '{default: '0};
    logic [irm_pkg::CNT_W-1:0]  gen_tx [16] = '{default: '0};

    // floor(d * 125 / 128) without losing the top bits
    function automatic logic [irm_pkg::CNT_W-1:0] kilo_scale(logic [irm_pkg::CNT_W-1:0] d);
        return (d >> irm_pkg::KILO_SHIFT) * 64'd125
             + (((d & 64'd127) * 64'd125) >> irm_pkg::KILO_SHIFT);
    endfunction

    function automatic void split_rate(input logic [irm_pkg::CNT_W-1:0] kd,
                                       input logic [irm_pkg::TIME_W-1:0] ms,
                                       output logic [irm_pkg::CNT_W-1:0] whole,
                                       output logic [irm_pkg::FRAC_W-1:0] frac);
        logic [irm_pkg::CNT_W-1:0] t64;
        logic [irm_pkg::CNT_W-1:0] rem;
        t64   = {32'd0, ms};
        whole = kd / t64;
        rem   = kd % t64;
        frac  = irm_pkg::FRAC_W'((rem * 64'd1000) / t64);
    endfunction

    // strict greater-than, whole part first
    function automatic logic beats(logic [irm_pkg::CNT_W-1:0] w, logic [irm_pkg::FRAC_W-1:0] f,
                                   logic [irm_pkg::CNT_W-1:0] pw,
                                   logic [irm_pkg::FRAC_W-1:0] pf);
        return (w > pw) || (w == pw && f > pf);
    endfunction

    function automatic rate_result_t predict_rates(sample_t smp);
        rate_result_t              r;
        logic [irm_pkg::CNT_W-1:0] rx_now;
        logic [irm_pkg::CNT_W-1:0] tx_now;
        logic [irm_pkg::CNT_W-1:0] rx_diff;
        logic [irm_pkg::CNT_W-1:0] tx_diff;
        logic [irm_pkg::CNT_W:0]   whole_sum;
        logic [10:0]               frac_sum;
        logic                      carry;
        int unsigned               i;
        r       = '0;
        i       = 32'(smp.iface);
        rx_now  = unit_bytes ? smp.rx : (smp.rx << irm_pkg::UNIT_SHIFT);
        tx_now  = unit_bytes ? smp.tx : (smp.tx << irm_pkg::UNIT_SHIFT);
        rx_diff = rx_now - prev_rx[i];
        tx_diff = tx_now - prev_tx[i];
        prev_rx[i] = rx_now;
        prev_tx[i] = tx_now;
        if (!seen[i]) begin
            // first sample only records, even with zero elapsed time
            seen[i]  = 1'b1;
            r.status = irm_pkg::ST_FIRST;
        end else if (smp.ms == '0) begin
            r.status = irm_pkg::ST_ZERO_TIME;
        end else begin
            r.status = irm_pkg::ST_VALID;
            split_rate(kilo_scale(rx_diff), smp.ms, r.rx_whole, r.rx_frac);
            split_rate(kilo_scale(tx_diff), smp.ms, r.tx_whole, r.tx_frac);
            if (beats(r.rx_whole, r.rx_frac, peak_rx_w[i], peak_rx_f[i])) begin
                peak_rx_w[i] = r.rx_whole;
                peak_rx_f[i] = r.rx_frac;
            end
            if (beats(r.tx_whole, r.tx_frac, peak_tx_w[i], peak_tx_f[i])) begin
                peak_tx_w[i] = r.tx_whole;
                peak_tx_f[i] = r.tx_frac;
            end
            frac_sum = r.rx_frac + r.tx_frac;
            carry    = (frac_sum >= 11'(irm_pkg::FRAC_LIMIT));
            if (carry) frac_sum = frac_sum - 11'(irm_pkg::FRAC_LIMIT);
            whole_sum = r.rx_whole + r.tx_whole;
            if (whole_sum[irm_pkg::CNT_W] || (carry && &whole_sum[irm_pkg::CNT_W-1:0])) begin
                // saturate
                r.sum_whole = '1;
                r.sum_frac  = irm_pkg::FRAC_W'(irm_pkg::FRAC_MAX);
            end else begin
                r.sum_whole = whole_sum[irm_pkg::CNT_W-1:0] + carry;
                r.sum_frac  = frac_sum[irm_pkg::FRAC_W-1:0];
            end
        end
        r.rx_peak_whole = peak_rx_w[i];
        r.rx_peak_frac  = peak_rx_f[i];
        r.tx_peak_whole = peak_tx_w[i];
        r.tx_peak_frac  = peak_tx_f[i];
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // sender: next word is chosen at the falling edge once the last one has gone
    always @(negedge aclk) begin
        sample_t smp;
        if (!s_tvalid || took_word) begin
            if (pending_samples.size() != 0 && (quiet || $urandom_range(0, 99) >= 25)) begin
                smp = pending_samples.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {smp.ms, smp.tx, smp.rx};
                s_tuser  <= smp.iface;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack   <= hold_req;
            stall_left <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= 25);
        end
    end

    // monitor: predict on input handshake, check on output handshake
    always @(posedge aclk) begin
        sample_t      smp;
        rate_result_t want;
        rate_result_t got;
        took_word <= s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                smp.rx    = s_tdata[63:0];
                smp.tx    = s_tdata[127:64];
                smp.ms    = s_tdata[159:128];
                smp.iface = s_tuser;
                expected_rates.push_back(predict_rates(smp));
                samples_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_rates.size() == 0) begin
                    $error("result word with no expectation waiting");
                    mismatch_count++;
                end else begin
                    want = expected_rates.pop_front();
                    got  = {m_tdata[369:0], irm_pkg::status_t'(m_tuser)};
                    check_field("rx_whole",      want.rx_whole,      got.rx_whole);
                    check_field("rx_frac",       want.rx_frac,       got.rx_frac);
                    check_field("tx_whole",      want.tx_whole,      got.tx_whole);
                    check_field("tx_frac",       want.tx_frac,       got.tx_frac);
                    check_field("sum_whole",     want.sum_whole,     got.sum_whole);
                    check_field("sum_frac",      want.sum_frac,      got.sum_frac);
                    check_field("rx_peak_whole", want.rx_peak_whole, got.rx_peak_whole);
                    check_field("rx_peak_frac",  want.rx_peak_frac,  got.rx_peak_frac);
                    check_field("tx_peak_whole", want.tx_peak_whole, got.tx_peak_whole);
                    check_field("tx_peak_frac",  want.tx_peak_frac,  got.tx_peak_frac);
                    check_field("status",        want.status,        got.status);
                    check_field("pad",           '0,                 m_tdata[375:370]);
                end
            end
        end
    end

    task automatic push_sample(int unsigned idx, logic [63:0] rx, logic [63:0] tx,
                               logic [31:0] ms);
        sample_t smp;
        smp.iface = irm_pkg::IDX_IN_W'(idx);
        smp.rx    = rx;
        smp.tx    = tx;
        smp.ms    = ms;
        gen_rx[idx] = rx;
        gen_tx[idx] = tx;
        pending_samples.push_back(smp);
        samples_queued++;
    endtask

    // random magnitude, from zero up to the whole counter range
    function automatic logic [63:0] random_delta();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v >> $urandom_range(0, 63);
    endfunction

    task automatic push_random_sample();
        int unsigned idx;
        int unsigned kind;
        logic [63:0] rx;
        logic [63:0] tx;
        logic [31:0] ms;
        idx  = $urandom_range(0, 15);
        kind = $urandom_range(0, 99);
        rx   = gen_rx[idx] + random_delta();
        tx   = gen_tx[idx] + random_delta();
        ms   = $urandom_range(1, 5000);
        if (kind < 5) begin
            ms = '0;
        end else if (kind < 10) begin
            ms = $urandom;
        end else if (kind < 15) begin
            ms = 32'd1;
        end else if (kind < 22) begin
            // noise: counters anywhere, often going backwards
            rx = {$urandom, $urandom};
            tx = {$urandom, $urandom};
        end
        push_sample(idx, rx, tx, ms);
    endtask

    // wait until everything queued has been taken and answered
    task automatic drain();
        while (pending_samples.size() != 0 || samples_taken != samples_queued
               || expected_rates.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_count_unit(logic v);
        @(negedge aclk);
        cfg_wen    <= 1'b1;
        cfg_wdata  <= v;
        unit_bytes = v;
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        set_count_unit(1'b0);

        // directed: basic rate, zero time, zero delta, small fractions
        push_sample(0, 64'd100,  64'd200,  32'd1000);
        push_sample(0, 64'd1100, 64'd5200, 32'd1000);
        push_sample(0, 64'd1100, 64'd5200, 32'd0);
        push_sample(0, 64'd1100, 64'd5200, 32'd1);
        push_sample(0, 64'd1103, 64'd5207, 32'd3);
        // first sample with zero time still records; then a saturating sum
        push_sample(1, 64'd0, 64'd0, 32'd0);
        push_sample(1, 64'h1FFF_FFFF_FFFF_FFFF, 64'h1FFF_FFFF_FFFF_FFFF, 32'd1);
        push_sample(1, 64'h1FFF_FFFF_FFFF_FFFF, 64'h1FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        // counter wrap
        push_sample(2, 64'hFFFF_FFFF_FFFF_FF00, 64'd0, 32'd10);
        push_sample(2, 64'h0000_0000_0000_0100, 64'hFFFF_FFFF_FFFF_FFFF, 32'd10);
        // peak held against equal and lower rates
        push_sample(3, 64'd0, 64'd0, 32'd5);
        push_sample(3, 64'd1, 64'd2, 32'd3);
        push_sample(3, 64'd2, 64'd4, 32'd3);
        push_sample(3, 64'd3, 64'd5, 32'd3);
        push_sample(3, 64'd5, 64'd8, 32'd3);
        // top interface, extreme values
        push_sample(15, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        push_sample(15, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
        drain();

        // byte counting; stored bit-scaled counters are not corrected
        set_count_unit(1'b1);
        push_sample(0,  64'd2100, 64'd6200, 32'd1000);
        push_sample(15, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'd1);
        push_sample(2,  64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 32'd2);
        push_sample(4,  64'd7, 64'd9, 32'd0);
        drain();

        // random, bits, idling on both sides
        set_count_unit(1'b0);
        repeat (PHASE_ITEMS) push_random_sample();
        drain();

        // random, bytes
        set_count_unit(1'b1);
        repeat (PHASE_ITEMS) push_random_sample();
        drain();

        // long receiver hold-off with the sender pushing, then no idling at all
        @(posedge aclk);
        quiet    = 1'b1;
        hold_req = ~hold_req;
        repeat (PHASE_ITEMS) push_random_sample();
        drain();
        @(posedge aclk);
        quiet = 1'b0;

        // random, back to bits
        set_count_unit(1'b0);
        repeat (PHASE_ITEMS) push_random_sample();
        drain();

        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog, several times the slowest correct run
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
